// ----- src/gmb_pkg.sv -----
// ============================================================================
// gmb_pkg
// Shared types and constants of the greedy meshlet builder: sequencer states,
// configuration register indexes, register widths and reset values.
// ============================================================================
`default_nettype none

package gmb_pkg;

    // Width of a configuration register and of a slot-map entry.
    localparam int LIMIT_W = 7;
    localparam int SLOT_W  = 7;

    // Width of the register index on the configuration port.
    localparam int CFG_ADDR_W = 1;

    // Slot-map code for a vertex that is not in the current meshlet.
    localparam logic [SLOT_W-1:0] ABSENT_SLOT = 7'h7f;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_VERTEX_LIMIT   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_TRIANGLE_LIMIT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [LIMIT_W-1:0] VERTEX_LIMIT_RESET   = 7'd64;
    localparam logic [LIMIT_W-1:0] TRIANGLE_LIMIT_RESET = 7'd126;

    // Smallest legal limits; smaller written values saturate up to these.
    localparam logic [LIMIT_W-1:0] VERTEX_LIMIT_MIN   = 7'd3;
    localparam logic [LIMIT_W-1:0] TRIANGLE_LIMIT_MIN = 7'd1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_INIT,    // post-reset sweep that marks every slot-map entry absent
        ST_IDLE,    // waiting for a triangle
        ST_RD_A,    // slot-map read of corner a
        ST_RD_B,    // slot-map read of corner b
        ST_RD_C,    // slot-map read of corner c
        ST_CHECK,   // vertex and triangle limit check
        ST_CLOSE,   // sweep that returns the meshlet's map entries to absent
        ST_INS_A,   // append corner a if absent
        ST_INS_B,   // append corner b if absent
        ST_INS_C,   // append corner c if absent
        ST_EMIT     // load the result register
    } state_t;

endpackage : gmb_pkg

`default_nettype wire

// ----- src/greedy_meshlet_builder_core.sv -----
// ============================================================================
// greedy_meshlet_builder_core
// Greedy meshlet builder: packs a stream of triangles into meshlets bounded
// by a vertex limit and a triangle limit, with a slot map in block memory.
// ============================================================================
// Usage
//   Triangles enter on the s_ stream, one beat per triangle (three global
//   vertex indices, tlast marks the final triangle of a mesh). Each triangle
//   gives exactly one beat on the m_ stream: the local slots of its corners,
//   the vertices newly appended to the meshlet, a flag for a meshlet that
//   started before it, and tlast when the mesh (and its meshlet) ends.
//   The limits are written through cfg_we / cfg_addr / cfg_wdata while the
//   block is idle; out-of-range values saturate into the legal range.
// Timing
//   One single-port slot-map memory serves every lookup, insert and clear,
//   so the block works on one triangle at a time. A triangle passes through
//   an accepting idle state, three map reads, a limit check, three inserts
//   and a result load; its beat is valid once the result load is done.
//   A meshlet close, before a triangle or after a final one, adds one map
//   write per meshlet vertex, each fed by a registered vertex list read,
//   and then a step that clears the counts.
// Reset and stalls
//   After reset the block sweeps the whole slot map to absent, one entry a
//   cycle, with s_tready low; configuration writes are taken throughout.
//   A stalled receiver holds the result register; the next triangle runs
//   up to its result load and waits there.
// ============================================================================
`default_nettype none

module greedy_meshlet_builder_core #(
    parameter int MAX_VERTICES      = 65536,  // slot-map depth, a power of two
    parameter int MESHLET_VERTICES  = 64,     // vertex list depth, 3..126
    parameter int MESHLET_TRIANGLES = 126     // triangle bound, 1..255
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    // Configuration write port.
    input  wire logic                            cfg_we,
    input  wire logic [gmb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [gmb_pkg::LIMIT_W-1:0]     cfg_wdata,

    // Triangle input stream.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata, lowest bit up: vert_a[15:0], vert_b[31:16], vert_c[47:32]
    input  wire logic [47:0]                     s_tdata,
    input  wire logic                            s_tlast,   // last_triangle

    // Result stream.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata, lowest bit up: starts_new_meshlet[0], local_a[6:1],
    // local_b[12:7], local_c[18:13], added_count[20:19],
    // added_vertex_0[36:21], added_vertex_1[52:37], added_vertex_2[68:53],
    // zero fill [71:69]
    output logic [71:0]                          m_tdata,
    output logic                                 m_tlast    // ends_mesh
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int AW   = $clog2(MAX_VERTICES);            // slot-map address
    localparam int LAW  = $clog2(MESHLET_VERTICES);        // vertex list address
    localparam int VCW  = $clog2(MESHLET_VERTICES + 1);    // vertex count
    localparam int TCW  = $clog2(MESHLET_TRIANGLES + 1);   // triangle count
    localparam int CW0  = (VCW > TCW) ? VCW : TCW;
    localparam int CW1  = (CW0 > gmb_pkg::LIMIT_W) ? CW0 : gmb_pkg::LIMIT_W;
    localparam int CW   = CW1 + 2;                          // limit compare width

    localparam logic [AW-1:0]  INIT_LAST = {AW{1'b1}};
    localparam logic [VCW-1:0] VC_MAX    = VCW'(MESHLET_VERTICES);

    // The slot map is indexed by the global vertex modulo its depth.
    function automatic logic [AW-1:0] map_index(input logic [15:0] v);
        logic [AW+15:0] wide;
        wide = {{AW{1'b0}}, v};
        return wide[AW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    gmb_pkg::state_t state_reg, state_next;

    logic [gmb_pkg::LIMIT_W-1:0] vlim_reg;
    logic [gmb_pkg::LIMIT_W-1:0] tlim_reg;

    logic [AW-1:0]  init_cnt_reg;
    logic [VCW-1:0] vc_reg;
    logic [TCW-1:0] tc_reg;
    logic [VCW-1:0] sweep_idx_reg;
    logic           sweep_pend_reg;
    logic           post_close_reg;   // current sweep follows a final triangle
    logic           out_valid_reg;

    // Payload of the triangle under work.
    logic [15:0]                vert_reg [3];
    logic                       last_reg;
    logic [gmb_pkg::SLOT_W-1:0] slot_reg [3];
    logic                       starts_reg;
    logic [1:0]                 added_cnt_reg;
    logic [15:0]                added_reg [3];
    logic [71:0]                out_data_reg;
    logic                       out_last_reg;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic [gmb_pkg::SLOT_W-1:0] slot_map [MAX_VERTICES];
    logic [gmb_pkg::SLOT_W-1:0] map_rdata;
    logic                       map_we;
    logic [AW-1:0]              map_addr;
    logic [gmb_pkg::SLOT_W-1:0] map_wdata;

    logic [15:0]    vlist [MESHLET_VERTICES];
    logic [15:0]    vlist_rdata;
    logic           vlist_we;
    logic           vlist_re;
    logic [LAW-1:0] vlist_waddr;
    logic [LAW-1:0] vlist_raddr;

    // Global vertex of the corner under insertion.
    logic [15:0]    vert_cur;

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            slot_map[map_addr] <= map_wdata;
        end
        else
        begin
            map_rdata <= slot_map[map_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vlist_we)
        begin
            vlist[vlist_waddr] <= vert_cur;
        end
        if (vlist_re)
        begin
            vlist_rdata <= vlist[vlist_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic [gmb_pkg::LIMIT_W-1:0] vlim_eff;
    logic [gmb_pkg::LIMIT_W-1:0] tlim_eff;
    logic [1:0]                  absent_cnt;
    logic                        need_close;
    logic                        sweep_issue;
    logic                        sweep_done;
    logic [1:0]                  corner;
    logic [gmb_pkg::SLOT_W-1:0]  slot_cur;
    logic                        ins_take;
    logic                        emit_ok;
    logic                        ins_state;

    // Limits saturate into their legal ranges.
    always_comb
    begin
        if (vlim_reg < gmb_pkg::VERTEX_LIMIT_MIN)
            vlim_eff = gmb_pkg::VERTEX_LIMIT_MIN;
        else if (CW'(vlim_reg) > CW'(MESHLET_VERTICES))
            vlim_eff = gmb_pkg::LIMIT_W'(MESHLET_VERTICES);
        else
            vlim_eff = vlim_reg;

        if (tlim_reg < gmb_pkg::TRIANGLE_LIMIT_MIN)
            tlim_eff = gmb_pkg::TRIANGLE_LIMIT_MIN;
        else if (CW'(tlim_reg) > CW'(MESHLET_TRIANGLES))
            tlim_eff = gmb_pkg::LIMIT_W'(MESHLET_TRIANGLES);
        else
            tlim_eff = tlim_reg;
    end

    // Corner c's map entry arrives in the check cycle straight from memory.
    // A repeated absent vertex counts once per corner here.
    always_comb
    begin
        absent_cnt = 2'((slot_reg[0] == gmb_pkg::ABSENT_SLOT) ? 1 : 0)
                   + 2'((slot_reg[1] == gmb_pkg::ABSENT_SLOT) ? 1 : 0)
                   + 2'((map_rdata   == gmb_pkg::ABSENT_SLOT) ? 1 : 0);
        need_close = (CW'(vc_reg) + CW'(absent_cnt) > CW'(vlim_eff))
                  || (CW'(tc_reg) + CW'(1) > CW'(tlim_eff));
    end

    // The close sweep reads the vertex list one entry a cycle and writes
    // the matching map entry to absent in the cycle after the read.
    assign sweep_issue = (sweep_idx_reg < vc_reg);
    assign sweep_done  = !sweep_issue && !sweep_pend_reg;

    // Corner under insertion.
    always_comb
    begin
        case (state_reg)
            gmb_pkg::ST_INS_B: corner = 2'd1;
            gmb_pkg::ST_INS_C: corner = 2'd2;
            default:           corner = 2'd0;
        endcase
    end

    assign ins_state = (state_reg == gmb_pkg::ST_INS_A)
                    || (state_reg == gmb_pkg::ST_INS_B)
                    || (state_reg == gmb_pkg::ST_INS_C);
    assign vert_cur  = vert_reg[corner];
    assign slot_cur  = slot_reg[corner];
    assign ins_take  = ins_state && (slot_cur == gmb_pkg::ABSENT_SLOT)
                    && (vc_reg < VC_MAX);
    assign emit_ok   = !out_valid_reg || m_tready;

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gmb_pkg::ST_INIT:
            begin
                if (init_cnt_reg == INIT_LAST)
                    state_next = gmb_pkg::ST_IDLE;
            end
            gmb_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = gmb_pkg::ST_RD_A;
            end
            gmb_pkg::ST_RD_A:  state_next = gmb_pkg::ST_RD_B;
            gmb_pkg::ST_RD_B:  state_next = gmb_pkg::ST_RD_C;
            gmb_pkg::ST_RD_C:  state_next = gmb_pkg::ST_CHECK;
            gmb_pkg::ST_CHECK:
            begin
                if (need_close)
                    state_next = gmb_pkg::ST_CLOSE;
                else
                    state_next = gmb_pkg::ST_INS_A;
            end
            gmb_pkg::ST_CLOSE:
            begin
                if (sweep_done)
                    state_next = post_close_reg ? gmb_pkg::ST_IDLE : gmb_pkg::ST_INS_A;
            end
            gmb_pkg::ST_INS_A: state_next = gmb_pkg::ST_INS_B;
            gmb_pkg::ST_INS_B: state_next = gmb_pkg::ST_INS_C;
            gmb_pkg::ST_INS_C: state_next = gmb_pkg::ST_EMIT;
            gmb_pkg::ST_EMIT:
            begin
                if (emit_ok)
                    state_next = last_reg ? gmb_pkg::ST_CLOSE : gmb_pkg::ST_IDLE;
            end
            default:           state_next = gmb_pkg::ST_INIT;
        endcase
    end

    // ------------------------------------------------------------------
    // Output and memory control logic
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready    = 1'b0;
        map_we      = 1'b0;
        map_addr    = map_index(vert_cur);
        map_wdata   = gmb_pkg::ABSENT_SLOT;
        vlist_we    = 1'b0;
        vlist_re    = 1'b0;
        vlist_waddr = vc_reg[LAW-1:0];
        vlist_raddr = sweep_idx_reg[LAW-1:0];
        case (state_reg)
            gmb_pkg::ST_INIT:
            begin
                map_we   = 1'b1;
                map_addr = init_cnt_reg;
            end
            gmb_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            gmb_pkg::ST_RD_A:  map_addr = map_index(vert_reg[0]);
            gmb_pkg::ST_RD_B:  map_addr = map_index(vert_reg[1]);
            gmb_pkg::ST_RD_C:  map_addr = map_index(vert_reg[2]);
            gmb_pkg::ST_CLOSE:
            begin
                vlist_re = sweep_issue;
                map_we   = sweep_pend_reg;
                map_addr = map_index(vlist_rdata);
            end
            gmb_pkg::ST_INS_A, gmb_pkg::ST_INS_B, gmb_pkg::ST_INS_C:
            begin
                map_we    = ins_take;
                map_wdata = gmb_pkg::SLOT_W'(vc_reg);
                vlist_we  = ins_take;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gmb_pkg::ST_INIT;
            vlim_reg       <= gmb_pkg::VERTEX_LIMIT_RESET;
            tlim_reg       <= gmb_pkg::TRIANGLE_LIMIT_RESET;
            init_cnt_reg   <= '0;
            vc_reg         <= '0;
            tc_reg         <= '0;
            sweep_idx_reg  <= '0;
            sweep_pend_reg <= 1'b0;
            post_close_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_addr)
                    gmb_pkg::REG_VERTEX_LIMIT:   vlim_reg <= cfg_wdata;
                    gmb_pkg::REG_TRIANGLE_LIMIT: tlim_reg <= cfg_wdata;
                    default:                     vlim_reg <= vlim_reg;
                endcase
            end

            if (state_reg == gmb_pkg::ST_INIT)
                init_cnt_reg <= init_cnt_reg + AW'(1);

            // A new result load wins over the receiver taking the old one.
            if (state_reg == gmb_pkg::ST_EMIT && emit_ok)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                gmb_pkg::ST_CHECK:
                begin
                    sweep_idx_reg  <= '0;
                    sweep_pend_reg <= 1'b0;
                    post_close_reg <= 1'b0;
                end
                gmb_pkg::ST_CLOSE:
                begin
                    sweep_pend_reg <= sweep_issue;
                    if (sweep_issue)
                        sweep_idx_reg <= sweep_idx_reg + VCW'(1);
                    if (sweep_done)
                    begin
                        vc_reg <= '0;
                        tc_reg <= '0;
                    end
                end
                gmb_pkg::ST_INS_A, gmb_pkg::ST_INS_B, gmb_pkg::ST_INS_C:
                begin
                    if (ins_take)
                        vc_reg <= vc_reg + VCW'(1);
                end
                gmb_pkg::ST_EMIT:
                begin
                    if (emit_ok)
                    begin
                        tc_reg         <= tc_reg + TCW'(1);
                        sweep_idx_reg  <= '0;
                        sweep_pend_reg <= 1'b0;
                        post_close_reg <= 1'b1;
                    end
                end
                default:
                begin
                    sweep_pend_reg <= 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            gmb_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    vert_reg[0]   <= s_tdata[15:0];
                    vert_reg[1]   <= s_tdata[31:16];
                    vert_reg[2]   <= s_tdata[47:32];
                    last_reg      <= s_tlast;
                    added_cnt_reg <= '0;
                    added_reg[0]  <= '0;
                    added_reg[1]  <= '0;
                    added_reg[2]  <= '0;
                end
            end
            gmb_pkg::ST_RD_B:  slot_reg[0] <= map_rdata;
            gmb_pkg::ST_RD_C:  slot_reg[1] <= map_rdata;
            gmb_pkg::ST_CHECK:
            begin
                starts_reg <= need_close;
                // After a close every map entry is absent again.
                if (need_close)
                begin
                    slot_reg[0] <= gmb_pkg::ABSENT_SLOT;
                    slot_reg[1] <= gmb_pkg::ABSENT_SLOT;
                    slot_reg[2] <= gmb_pkg::ABSENT_SLOT;
                end
                else
                begin
                    slot_reg[2] <= map_rdata;
                end
            end
            gmb_pkg::ST_INS_A, gmb_pkg::ST_INS_B, gmb_pkg::ST_INS_C:
            begin
                if (ins_take)
                begin
                    added_reg[added_cnt_reg] <= vert_cur;
                    added_cnt_reg            <= added_cnt_reg + 2'd1;
                    // Later corners on the same map entry share the new slot.
                    for (int k = 0; k < 3; k++)
                    begin
                        if (k >= int'(corner)
                            && map_index(vert_reg[k]) == map_index(vert_cur))
                            slot_reg[k] <= gmb_pkg::SLOT_W'(vc_reg);
                    end
                end
            end
            gmb_pkg::ST_EMIT:
            begin
                if (emit_ok)
                begin
                    out_data_reg <= {3'b000,
                                     added_reg[2], added_reg[1], added_reg[0],
                                     added_cnt_reg,
                                     slot_reg[2][5:0], slot_reg[1][5:0], slot_reg[0][5:0],
                                     starts_reg};
                    out_last_reg <= last_reg;
                end
            end
            default:
            begin
                last_reg <= last_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_vc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg <= VC_MAX)
        else $error("vertex count passed the meshlet vertex capacity");

    a_tc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        TCW'(tc_reg) <= TCW'(MESHLET_TRIANGLES))
        else $error("triangle count passed the meshlet triangle capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a triangle is under work");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gmb_pkg::ST_CLOSE && sweep_done) |=> (vc_reg == '0 && tc_reg == '0))
        else $error("meshlet close left counts behind");

    a_no_emit_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("pending result overwritten under backpressure");

endmodule : greedy_meshlet_builder_core

`default_nettype wire
